>>> hw/rtl/mrf_pkg.sv
`default_nettype none

package mrf_pkg;

	// Field widths of one word on either channel.
	localparam int ACTION_W = 2;
	localparam int SIZE_W   = 12;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 3;

	// Ring geometry.
	localparam int RING_BYTES_DEF = 4096;
	localparam int HEADER_BYTES   = 8;
	localparam logic [31:0] CANARY = 32'hDEADBEEF;

	// Request codes.
	localparam logic [ACTION_W-1:0] ACT_PUT_HDR  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_PUT_DATA = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_GET_HDR  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_GET_DATA = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CORRUPT   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NO_OPEN   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_BAD_CAP   = 3'd6;

	// One result word as it passes from the sequencer to the output register.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SIZE_W-1:0]   msg_length;
		logic [BYTE_W-1:0]   data_out;
		logic                last;
		logic                queue_empty;
	} mrf_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/mrf_ram.sv
`default_nettype none

module mrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/mrf_ctrl.sv
`default_nettype none

module mrf_ctrl #(
	parameter int RING_BYTES = mrf_pkg::RING_BYTES_DEF,
	localparam int PTR_W = $clog2(RING_BYTES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mrf_pkg::ACTION_W-1:0]  action,
	input  logic [mrf_pkg::SIZE_W-1:0]    msg_size,
	input  logic [mrf_pkg::BYTE_W-1:0]    data_in,
	output logic                          ram_we,
	output logic [PTR_W-1:0]              ram_waddr,
	output logic [mrf_pkg::BYTE_W-1:0]    ram_wdata,
	output logic [PTR_W-1:0]              ram_raddr,
	input  logic [mrf_pkg::BYTE_W-1:0]    ram_rdata,
	output logic                          res_load,
	output mrf_pkg::mrf_result_t          res,
	input  logic                          res_ready
);

	import mrf_pkg::*;

	localparam int CMP_W = (PTR_W + 1 > SIZE_W + 1) ? PTR_W + 1 : SIZE_W + 1;
	localparam logic [PTR_W:0]   RING_C = (PTR_W + 1)'(RING_BYTES);
	localparam logic [PTR_W-1:0] HDR_P  = PTR_W'(HEADER_BYTES);

	// Sequencer states.
	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_PUT_HDR   = 3'd1;
	localparam logic [2:0] S_GET_CHK   = 3'd2;
	localparam logic [2:0] S_GET_RD    = 3'd3;
	localparam logic [2:0] S_GET_EVAL  = 3'd4;
	localparam logic [2:0] S_DATA_WAIT = 3'd5;
	localparam logic [2:0] S_DONE      = 3'd6;

	logic [2:0]          state_q;
	logic [PTR_W-1:0]    read_q;
	logic [PTR_W-1:0]    commit_q;
	logic [PTR_W-1:0]    fill_q;
	logic [SIZE_W-1:0]   put_owed_q;
	logic [PTR_W-1:0]    get_owed_q;
	logic                put_open_q;
	logic                get_open_q;
	logic [3:0]          cnt_q;
	logic [SIZE_W-1:0]   size_q;
	logic [63:0]         hdr_q;
	logic [STATUS_W-1:0] status_q;
	logic [SIZE_W-1:0]   len_q;
	logic [BYTE_W-1:0]   dout_q;
	logic                last_q;

	logic [PTR_W:0]      diff;
	logic [PTR_W:0]      used;
	logic [PTR_W:0]      free_bytes;
	logic                is_full;
	logic [63:0]         hdr_word;
	logic [BYTE_W-1:0]   hdr_byte;
	logic [31:0]         hdr_len;
	logic [31:0]         hdr_canary;
	logic [31:0]         room;
	logic [PTR_W-1:0]    fill_next;
	logic                accept;

	// Pointer advance with wrap at the ring size; both operands stay below it.
	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
			input logic [PTR_W-1:0] n);
		logic [PTR_W:0] s;
		s = {1'b0, p} + {1'b0, n};
		if (s >= RING_C) begin
			s = s - RING_C;
		end
		return s[PTR_W-1:0];
	endfunction

	// Occupancy of committed bytes and the space left for a new put.
	always_comb begin
		diff       = {1'b0, commit_q} - {1'b0, read_q};
		used       = diff[PTR_W] ? diff + RING_C : diff;
		free_bytes = RING_C - used;
		is_full    = CMP_W'(free_bytes) <= CMP_W'(msg_size) + CMP_W'(HEADER_BYTES);
	end

	// Header bytes as stored: length little endian, then the canary.
	assign hdr_word   = {CANARY, 20'd0, size_q};
	assign hdr_byte   = hdr_word[{cnt_q[2:0], 3'b000} +: BYTE_W];
	assign hdr_len    = hdr_q[31:0];
	assign hdr_canary = hdr_q[63:32];
	assign room       = 32'(used) - 32'(HEADER_BYTES);
	assign fill_next  = ptr_add(fill_q, PTR_W'(1));

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// Memory port steering.
	assign ram_we    = (accept && action == ACT_PUT_DATA && put_open_q) ||
			(state_q == S_PUT_HDR);
	assign ram_waddr = fill_q;
	assign ram_wdata = (state_q == S_PUT_HDR) ? hdr_byte : data_in;
	assign ram_raddr = (state_q == S_GET_RD) ? ptr_add(read_q, PTR_W'(cnt_q[2:0])) : read_q;

	// Result handed to the output register.
	assign res_load        = (state_q == S_DONE);
	assign res.status      = status_q;
	assign res.msg_length  = len_q;
	assign res.data_out    = dout_q;
	assign res.last        = last_q;
	assign res.queue_empty = (read_q == commit_q);

	// Main sequencer: pointer state, header writes and reads, result build.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			read_q     <= '0;
			commit_q   <= '0;
			fill_q     <= '0;
			put_owed_q <= '0;
			get_owed_q <= '0;
			put_open_q <= 1'b0;
			get_open_q <= 1'b0;
			cnt_q      <= '0;
			size_q     <= '0;
			hdr_q      <= '0;
			status_q   <= ST_OK;
			len_q      <= '0;
			dout_q     <= '0;
			last_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= ST_OK;
						len_q    <= '0;
						dout_q   <= '0;
						last_q   <= 1'b0;
						unique case (action)
							ACT_PUT_HDR: begin
								// Any open put is abandoned first.
								put_open_q <= 1'b0;
								put_owed_q <= '0;
								fill_q     <= commit_q;
								if (is_full) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else begin
									size_q  <= msg_size;
									cnt_q   <= '0;
									state_q <= S_PUT_HDR;
								end
							end
							ACT_PUT_DATA: begin
								if (!put_open_q) begin
									status_q <= ST_NO_OPEN;
								end else begin
									fill_q     <= fill_next;
									put_owed_q <= put_owed_q - SIZE_W'(1);
									if (put_owed_q == SIZE_W'(1)) begin
										commit_q   <= fill_next;
										put_open_q <= 1'b0;
									end
								end
								state_q <= S_DONE;
							end
							ACT_GET_HDR: begin
								// Skip the unread rest of an open message.
								size_q <= msg_size;
								if (get_open_q) begin
									read_q     <= ptr_add(read_q, get_owed_q);
									get_open_q <= 1'b0;
									get_owed_q <= '0;
								end
								state_q <= S_GET_CHK;
							end
							ACT_GET_DATA: begin
								if (!get_open_q) begin
									status_q <= ST_NO_OPEN;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_DATA_WAIT;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_PUT_HDR: begin
					fill_q <= fill_next;
					cnt_q  <= cnt_q + 4'd1;
					if (cnt_q == 4'd7) begin
						if (size_q == '0) begin
							commit_q <= fill_next;
						end else begin
							put_open_q <= 1'b1;
							put_owed_q <= size_q;
						end
						state_q <= S_DONE;
					end
				end
				S_GET_CHK: begin
					if (size_q == '0) begin
						status_q <= ST_BAD_CAP;
						state_q  <= S_DONE;
					end else if (used == '0) begin
						status_q <= ST_EMPTY;
						state_q  <= S_DONE;
					end else if (used < (PTR_W + 1)'(HEADER_BYTES)) begin
						status_q <= ST_CORRUPT;
						state_q  <= S_DONE;
					end else begin
						cnt_q   <= '0;
						state_q <= S_GET_RD;
					end
				end
				S_GET_RD: begin
					// Reads issue on counts 0 to 7; each byte lands one count later.
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q != 4'd0) begin
						hdr_q <= {ram_rdata, hdr_q[63:8]};
					end
					if (cnt_q == 4'd8) begin
						state_q <= S_GET_EVAL;
					end
				end
				S_GET_EVAL: begin
					if (hdr_canary != CANARY || hdr_len > room) begin
						status_q <= ST_CORRUPT;
					end else if (hdr_len > 32'(size_q)) begin
						status_q <= ST_TOO_SMALL;
						len_q    <= hdr_len[SIZE_W-1:0];
					end else begin
						len_q      <= hdr_len[SIZE_W-1:0];
						read_q     <= ptr_add(read_q, HDR_P);
						get_owed_q <= hdr_len[PTR_W-1:0];
						get_open_q <= (hdr_len != 32'd0);
					end
					state_q <= S_DONE;
				end
				S_DATA_WAIT: begin
					dout_q     <= ram_rdata;
					read_q     <= ptr_add(read_q, PTR_W'(1));
					get_owed_q <= get_owed_q - PTR_W'(1);
					if (get_owed_q == PTR_W'(1)) begin
						get_open_q <= 1'b0;
						last_q     <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/mrf_out.sv
`default_nettype none

module mrf_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  mrf_pkg::mrf_result_t          res,
	output logic                          ready,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mrf_pkg::STATUS_W-1:0]  status,
	output logic [mrf_pkg::SIZE_W-1:0]    msg_length,
	output logic [mrf_pkg::BYTE_W-1:0]    data_out,
	output logic                          last,
	output logic                          queue_empty
);

	import mrf_pkg::*;

	logic        valid_q;
	mrf_result_t data_q;

	// The register can take a new word when empty or when its word leaves now.
	assign ready = !valid_q || !out_stall;

	// Valid flag of the output word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load && ready) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Output word; held while the receiver stalls.
	always_ff @(posedge clk) begin
		if (load && ready) begin
			data_q <= res;
		end
	end

	assign out_valid   = valid_q;
	assign status      = data_q.status;
	assign msg_length  = data_q.msg_length;
	assign data_out    = data_q.data_out;
	assign last        = data_q.last;
	assign queue_empty = data_q.queue_empty;

endmodule

`default_nettype wire

>>> hw/rtl/message_ring_fifo_unit.sv
// Message ring FIFO. Requests arrive as words on the input channel (in_valid,
// in_stall, action, msg_size, data_in); every request gives exactly one result
// word on the output channel (out_valid, out_stall, status, msg_length,
// data_out, last, queue_empty). A word moves when valid is high and stall low.
// Messages sit in a single byte memory of RING_BYTES entries behind an
// eight-byte header (length, then canary); a put becomes visible only after
// its last data byte. Requests are handled one at a time by a sequencer that
// drives the memory's one write port and one registered read port:
//   put_data     one memory write
//   get_data     one memory read
//   put_header   eight header byte writes
//   get_header   up to eight header byte reads plus checks
// The result of one request sits in an output register, so the next request
// is taken while it waits; a stalled receiver holds the result steady and the
// block stops taking requests once a second result is ready to go out.
// Reset clears all pointers and open-message flags, leaving an empty queue;
// the memory contents are not cleared, as only committed bytes are ever read.
`default_nettype none

module message_ring_fifo_unit #(
	parameter int RING_BYTES = mrf_pkg::RING_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mrf_pkg::ACTION_W-1:0]  action,
	input  logic [mrf_pkg::SIZE_W-1:0]    msg_size,
	input  logic [mrf_pkg::BYTE_W-1:0]    data_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mrf_pkg::STATUS_W-1:0]  status,
	output logic [mrf_pkg::SIZE_W-1:0]    msg_length,
	output logic [mrf_pkg::BYTE_W-1:0]    data_out,
	output logic                          last,
	output logic                          queue_empty
);

	import mrf_pkg::*;

	localparam int PTR_W = $clog2(RING_BYTES);

	logic              ram_we;
	logic [PTR_W-1:0]  ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic [PTR_W-1:0]  ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;
	logic              res_load;
	logic              res_ready;
	mrf_result_t       res;

	// Byte store of the ring.
	mrf_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(RING_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Request sequencer and pointer state.
	mrf_ctrl #(
		.RING_BYTES(RING_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.msg_size (msg_size),
		.data_in  (data_in),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.res_load (res_load),
		.res      (res),
		.res_ready(res_ready)
	);

	// Output register towards the receiver.
	mrf_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (res_load),
		.res        (res),
		.ready      (res_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.msg_length (msg_length),
		.data_out   (data_out),
		.last       (last),
		.queue_empty(queue_empty)
	);

endmodule

`default_nettype wire
